[rtl/racwt_pkg.sv]
`default_nettype none
package racwt_pkg;

  localparam int ID_W      = 16;
  localparam int ACK_BITS  = 16;
  localparam int BIT_IDX_W = $clog2(ACK_BITS);

  typedef logic [ID_W-1:0]     id_t;
  typedef logic [ACK_BITS-1:0] ack_bits_t;

  // control from the sequencer to the ack builder
  typedef struct packed {
    logic clear;
    logic max_en;
    logic bits_en;
    logic tap_vld;
  } scan_ctl_t;

endpackage
`default_nettype wire

[rtl/racwt_if.sv]
`default_nettype none
interface racwt_in_if
  import racwt_pkg::*;
;
  logic valid;
  logic ready;
  id_t  packet_id;

  modport source (output valid, output packet_id, input ready);
  modport sink   (input valid, input packet_id, output ready);
endinterface

interface racwt_out_if
  import racwt_pkg::*;
;
  logic      valid;
  logic      ready;
  logic      is_repeat;
  id_t       ack_id;
  ack_bits_t ack_bits;
  logic      ack_valid;

  modport source (output valid, output is_repeat, output ack_id, output ack_bits,
                  output ack_valid, input ready);
  modport sink   (input valid, input is_repeat, input ack_id, input ack_bits,
                  input ack_valid, output ready);
endinterface
`default_nettype wire

[rtl/racwt_cell.sv]
`default_nettype none
module racwt_cell
  import racwt_pkg::*;
(
  input  wire logic clk,
  input  wire logic shift_en,
  input  wire id_t  din,
  input  wire id_t  probe,
  output id_t       q,
  output logic      hit
);

  id_t id_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      id_r <= din;
    end
  end

  assign q   = id_r;
  assign hit = (id_r == probe);

endmodule
`default_nettype wire

[rtl/racwt_scan.sv]
`default_nettype none
module racwt_scan
  import racwt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire scan_ctl_t ctl,
  input  wire id_t       tap,
  output id_t            ack_id,
  output ack_bits_t      ack_bits
);

  id_t       top_r;
  ack_bits_t bits_r;
  id_t       gap;
  logic      below;

  // distance below the ack, minus one
  assign below = (tap < top_r);
  assign gap   = top_r - tap - id_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r  <= '0;
      bits_r <= '0;
    end else if (ctl.clear) begin
      top_r  <= '0;
      bits_r <= '0;
    end else begin
      if (ctl.max_en && ctl.tap_vld && (tap > top_r)) begin
        top_r <= tap;
      end
      if (ctl.bits_en && ctl.tap_vld && below && (gap < id_t'(ACK_BITS))) begin
        bits_r[gap[BIT_IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  assign ack_id   = top_r;
  assign ack_bits = bits_r;

endmodule
`default_nettype wire

[rtl/recv_ack_window_tracker_top.sv]
`default_nettype none
// Channel | Dir | Handshake     | Payload
// in_if   | in  | valid / ready | packet_id[15:0]
// out_if  | out | valid / ready | is_repeat, ack_id[15:0], ack_bits[15:0], ack_valid
//
// An item passes through these steps in order: check and append, a full
// rotation of the ID chain for the maximum, another full rotation for the
// bitfield, then a load of the output register. While the store stays empty
// both rotations are skipped. rst_n clears fill count, held ack and bitfield.
// A stalled result holds the output register; the next item is taken meanwhile
// and waits in the last step until the register frees.
module recv_ack_window_tracker_top
  import racwt_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  racwt_in_if.sink    in_if,
  racwt_out_if.source out_if
);

  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CNT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [FILL_W-1:0] FULL     = FILL_W'(HISTORY_DEPTH);
  localparam logic [FILL_W-1:0] LAST_POS = FILL_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(HISTORY_DEPTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_MAX, S_BITS, S_EMIT} state_t;

  state_t            state_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              repeat_r;
  logic              out_valid_r, out_repeat_r, out_ack_valid_r;
  id_t               out_ack_id_r;
  ack_bits_t         out_ack_bits_r;

  id_t                      cell_q   [HISTORY_DEPTH];
  id_t                      cell_din [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] hit_vec, valid_vec;

  logic      accept, hit_any, is_new, shift_en, last_step;
  id_t       head_din;
  scan_ctl_t scan_ctl;
  id_t       ack_id;
  ack_bits_t ack_bits;

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign hit_any     = |(hit_vec & valid_vec);
  assign is_new      = accept && (in_if.packet_id != '0) && !hit_any;
  assign shift_en    = is_new || (state_r == S_MAX) || (state_r == S_BITS);
  // append at the head, otherwise rotate the tail around
  assign head_din    = is_new ? in_if.packet_id : cell_q[HISTORY_DEPTH-1];
  assign last_step   = (cnt_r == LAST_CNT);

  always_comb begin
    fill_nxt = fill_r;
    if (is_new && (fill_r != FULL)) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
  end

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_chain
    if (i == 0) begin : g_head
      assign cell_din[i] = head_din;
    end else begin : g_body
      assign cell_din[i] = cell_q[i-1];
    end
    assign valid_vec[i] = (FILL_W'(i) < fill_r);

    racwt_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .din      (cell_din[i]),
      .probe    (in_if.packet_id),
      .q        (cell_q[i]),
      .hit      (hit_vec[i])
    );
  end

  // tail holds the entry that started at position LAST_POS - cnt
  always_comb begin
    scan_ctl.clear   = accept && (fill_nxt != '0);
    scan_ctl.max_en  = (state_r == S_MAX);
    scan_ctl.bits_en = (state_r == S_BITS);
    scan_ctl.tap_vld = ((LAST_POS - FILL_W'(cnt_r)) < fill_r);
  end

  racwt_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .tap      (cell_q[HISTORY_DEPTH-1]),
    .ack_id   (ack_id),
    .ack_bits (ack_bits)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop a taken result unless the emit step reloads the register
      if (out_valid_r && out_if.ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            repeat_r <= (in_if.packet_id != '0) && hit_any;
            fill_r   <= fill_nxt;
            cnt_r    <= '0;
            state_r  <= (fill_nxt != '0) ? S_MAX : S_EMIT;
          end
        end
        S_MAX: begin
          cnt_r <= last_step ? '0 : cnt_r + CNT_W'(1);
          if (last_step) begin
            state_r <= S_BITS;
          end
        end
        S_BITS: begin
          cnt_r <= last_step ? '0 : cnt_r + CNT_W'(1);
          if (last_step) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r     <= 1'b1;
            out_repeat_r    <= repeat_r;
            out_ack_id_r    <= ack_id;
            out_ack_bits_r  <= ack_bits;
            out_ack_valid_r <= (fill_r != '0);
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.is_repeat = out_repeat_r;
  assign out_if.ack_id    = out_ack_id_r;
  assign out_if.ack_bits  = out_ack_bits_r;
  assign out_if.ack_valid = out_ack_valid_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL)
    else $error("fill count beyond history depth");

  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> fill_r >= $past(fill_r))
    else $error("fill count decreased");

  a_ack_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ack_valid_r |-> out_ack_id_r != '0)
    else $error("valid ack with zero id");

  a_bits_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ack_valid_r && (out_ack_id_r == id_t'(1)) |-> out_ack_bits_r == '0)
    else $error("ack bits set below id zero");

endmodule
`default_nettype wire
